FILE: rtl/mlbs_pkg.sv
package mlbs_pkg;

  // Default number of LED entries
  localparam int NUM_LEDS_DEF = 8;

  // Width of the LED count register and of the reported LED number
  localparam int CFG_W     = 4;
  localparam int LED_NUM_W = 3;

  // Action codes
  localparam logic [1:0] ACT_SOLID = 2'd0;
  localparam logic [1:0] ACT_BLINK = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // One input transaction
  typedef struct packed {
    logic [1:0]         action;
    logic signed [3:0]  led_index;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [15:0]        on_time;
    logic [15:0]        off_time;
    logic signed [15:0] cycle_limit;
    logic [31:0]        now_time;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic [LED_NUM_W-1:0] led_number;
    logic                 lit;
    logic [7:0]           out_red;
    logic [7:0]           out_green;
    logic [7:0]           out_blue;
    logic                 last_of_run;
  } res_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic load_step;
    logic scan_step;
    logic flush;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic load_done;
    logic scan_done;
  } dp_sts_t;

endpackage

FILE: rtl/mlbs_ctrl.sv
module mlbs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         action,
  input  mlbs_pkg::dp_sts_t  sts,
  output mlbs_pkg::dp_cmd_t  cmd,
  output logic               busy
);

  mlbs_pkg::state_t state;
  mlbs_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != mlbs_pkg::ST_IDLE);
    case (state)
      mlbs_pkg::ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (action)
            mlbs_pkg::ACT_SOLID: state_next = mlbs_pkg::ST_LOAD;
            mlbs_pkg::ACT_BLINK: state_next = mlbs_pkg::ST_LOAD;
            mlbs_pkg::ACT_TICK:  state_next = mlbs_pkg::ST_SCAN;
            default:             state_next = mlbs_pkg::ST_IDLE;
          endcase
        end
      end
      mlbs_pkg::ST_LOAD: begin
        // Write one entry, or sweep all entries in use
        cmd.load_step = 1'b1;
        if (sts.load_done) begin
          state_next = mlbs_pkg::ST_IDLE;
        end
      end
      mlbs_pkg::ST_SCAN: begin
        // Scan entries; release the held result as last at the end
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.flush  = 1'b1;
          state_next = mlbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mlbs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/mlbs_dp.sv
module mlbs_dp #(
  parameter int NUM_LEDS = mlbs_pkg::NUM_LEDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mlbs_pkg::item_t            item,
  input  logic                       cfg_we,
  input  logic [mlbs_pkg::CFG_W-1:0] cfg_data,
  input  mlbs_pkg::dp_cmd_t          cmd,
  output mlbs_pkg::dp_sts_t          sts,
  output mlbs_pkg::res_t             result,
  output logic                       result_valid
);

  localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int CNT_W = $clog2(NUM_LEDS + 1);

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [15:0]        on_ms;
    logic [15:0]        off_ms;
    logic signed [15:0] cyc;
    logic [31:0]        phase_start;
    logic               lit;
    logic               dirty;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    red: 8'h00, green: 8'h00, blue: 8'h00,
    on_ms: 16'h0000, off_ms: 16'h0000, cyc: 16'sd0,
    phase_start: 32'h0, lit: 1'b0, dirty: 1'b1
  };

  // Entry memory and per-entry valid bits
  entry_t              mem [NUM_LEDS];
  logic [NUM_LEDS-1:0] vld;

  logic [mlbs_pkg::CFG_W-1:0] led_count;
  mlbs_pkg::item_t            item_q;
  logic [CNT_W-1:0]           cnt;
  logic [CNT_W-1:0]           n_used;
  logic                       cnt_lt;
  logic                       single;
  logic                       idx_ok;

  logic                       we;
  logic [IDX_W-1:0]           waddr;
  entry_t                     wdata;
  logic                       re;
  logic [IDX_W-1:0]           raddr;

  entry_t                     rd_data;
  logic                       rd_vld;
  logic                       rd_v;
  logic [IDX_W-1:0]           rd_idx;

  entry_t                     cur;
  entry_t                     upd;
  entry_t                     ld_entry;
  logic                       emit;
  logic                       e_lit;

  mlbs_pkg::res_t             pend;
  logic                       pend_v;

  // Entries in use, clamped to the entry count
  always_comb begin
    logic [7:0] lc8;
    lc8    = 8'(led_count);
    n_used = CNT_W'((lc8 > 8'(NUM_LEDS)) ? 8'(NUM_LEDS) : lc8);
  end

  assign cnt_lt = (cnt < n_used);
  assign single = ~item_q.led_index[3];
  assign idx_ok = (8'(item_q.led_index[2:0]) < 8'(n_used));

  assign sts.load_done = single | ~cnt_lt;
  assign sts.scan_done = ~cnt_lt & ~rd_v;

  // Entry image of a solid or blink command
  always_comb begin
    ld_entry.red         = item_q.red;
    ld_entry.green       = item_q.green;
    ld_entry.blue        = item_q.blue;
    ld_entry.phase_start = 32'h0;
    ld_entry.lit         = 1'b1;
    ld_entry.dirty       = 1'b1;
    if (item_q.action == mlbs_pkg::ACT_BLINK) begin
      ld_entry.on_ms  = item_q.on_time;
      ld_entry.off_ms = item_q.off_time;
      ld_entry.cyc    = item_q.cycle_limit;
    end else begin
      ld_entry.on_ms  = 16'h0000;
      ld_entry.off_ms = 16'h0000;
      ld_entry.cyc    = -16'sd1;
    end
  end

  // Advance one entry on a tick
  always_comb begin
    logic [31:0] elapsed;
    logic [15:0] dur;
    cur     = rd_vld ? rd_data : ENTRY_RESET;
    upd     = cur;
    emit    = 1'b0;
    e_lit   = 1'b1;
    elapsed = item_q.now_time - cur.phase_start;
    dur     = cur.lit ? cur.on_ms : cur.off_ms;
    if (cur.on_ms == 16'h0000 && cur.off_ms == 16'h0000) begin
      if (cur.dirty) begin
        emit      = 1'b1;
        upd.dirty = 1'b0;
      end
    end else if (cur.dirty) begin
      emit            = 1'b1;
      upd.phase_start = item_q.now_time;
      upd.lit         = 1'b1;
      upd.dirty       = 1'b0;
    end else if (elapsed >= {16'h0000, dur}) begin
      emit = 1'b1;
      if (cur.lit) begin
        e_lit = 1'b0;
        if (cur.cyc == 16'sd1) begin
          // Last on phase of a bounded blink: settle to solid off
          upd.cyc    = 16'sd0;
          upd.lit    = 1'b0;
          upd.on_ms  = 16'h0000;
          upd.off_ms = 16'h0000;
        end else begin
          if (cur.cyc > 16'sd0) begin
            upd.cyc = cur.cyc - 16'sd1;
          end
          upd.lit         = 1'b0;
          upd.phase_start = item_q.now_time;
        end
      end else begin
        upd.lit         = 1'b1;
        upd.phase_start = item_q.now_time;
      end
    end
  end

  // Memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = rd_idx;
    wdata = upd;
    re    = 1'b0;
    raddr = cnt[IDX_W-1:0];
    if (cmd.load_step) begin
      wdata = ld_entry;
      if (single) begin
        we    = idx_ok;
        waddr = IDX_W'(item_q.led_index[2:0]);
      end else begin
        we    = cnt_lt;
        waddr = cnt[IDX_W-1:0];
      end
    end else if (cmd.scan_step) begin
      we = rd_v;
      re = cnt_lt;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
      rd_vld  <= vld[raddr];
      rd_idx  <= raddr;
    end
  end

  // Valid bits, count register, scan counter and read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      led_count <= '0;
      cnt       <= '0;
      rd_v      <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (cfg_we) begin
        led_count <= cfg_data;
      end
      if (cmd.capture) begin
        cnt <= '0;
      end else if ((cmd.load_step && !single && cnt_lt) || (cmd.scan_step && cnt_lt)) begin
        cnt <= cnt + CNT_W'(1);
      end
      rd_v <= re;
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
  end

  // Hold one result back so the final one can be marked last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= pend_v & ((cmd.scan_step & rd_v & emit) | cmd.flush);
      if (cmd.capture) begin
        pend_v <= 1'b0;
      end else if (cmd.scan_step && rd_v && emit) begin
        pend_v <= 1'b1;
      end else if (cmd.flush) begin
        pend_v <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.scan_step && rd_v && emit) begin
      pend <= '{
        led_number:  mlbs_pkg::LED_NUM_W'(rd_idx),
        lit:         e_lit,
        out_red:     cur.red,
        out_green:   cur.green,
        out_blue:    cur.blue,
        last_of_run: 1'b0
      };
      result <= pend;
    end else if (cmd.flush) begin
      result <= '{
        led_number:  pend.led_number,
        lit:         pend.lit,
        out_red:     pend.out_red,
        out_green:   pend.out_green,
        out_blue:    pend.out_blue,
        last_of_run: 1'b1
      };
    end
  end

endmodule

FILE: rtl/multi_led_blink_sequencer.sv
// Channel   Handshake              Payload
// --------  ---------------------  ----------------------------
// input     start & !busy          item   (mlbs_pkg::item_t)
// result    result_valid strobe    result (mlbs_pkg::res_t)
// config    cfg_we                 cfg_data (LED count in use)
//
// A tick keeps the block busy while it scans the n LEDs in use: the scan reads
// one entry per cycle through the single read port of the entry memory,
// evaluates it the next cycle and writes it back, and a final step at the end
// releases the held result, which shows marked last in the first cycle after
// busy falls.
// A command to one LED writes that entry; one to all LEDs writes each in turn.
// Reset is synchronous; all entries then read as dirty solid black, off.
// The receiver cannot stall: each result shows for exactly one cycle.
module multi_led_blink_sequencer #(
  parameter int NUM_LEDS = mlbs_pkg::NUM_LEDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  mlbs_pkg::item_t            item,
  input  logic                       cfg_we,
  input  logic [mlbs_pkg::CFG_W-1:0] cfg_data,
  output mlbs_pkg::res_t             result,
  output logic                       result_valid
);

  mlbs_pkg::dp_cmd_t cmd;
  mlbs_pkg::dp_sts_t sts;

  mlbs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (item.action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  mlbs_dp #(
    .NUM_LEDS (NUM_LEDS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid)
  );

  // Results come only out of a scan
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a preceding scan");

  // The last result ends the run
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_of_run) |=> !result_valid)
    else $error("result after last of run");

  // A result not marked last leaves the scan going
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last_of_run) |-> busy)
    else $error("run ended without a last result");

endmodule

FILE: tb/tb_multi_led_blink_sequencer.sv
`timescale 1ns / 1ps

module tb_multi_led_blink_sequencer;

  localparam int NUM_LEDS = mlbs_pkg::NUM_LEDS_DEF;
  // Cycles to let pass after the last drive before touching the LED count
  localparam int SETTLE_CYC = NUM_LEDS + 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_ITEMS_PER_PHASE = 18;
  localparam logic [1:0] ACT_NONE = 2'd3;

  // Per-LED effect entry of the predictor
  typedef struct {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [15:0]        on_ms;
    logic [15:0]        off_ms;
    logic signed [15:0] cycles_left;
    logic [31:0]        phase_start;
    logic               lit;
    logic               dirty;
  } led_effect_t;

  // One row of the directed stimulus
  typedef struct {
    bit              is_cfg;
    logic [3:0]      cfg_val;
    mlbs_pkg::item_t stim;
    bit              chk;
    mlbs_pkg::res_t  exp;
  } stim_row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  mlbs_pkg::item_t item = '0;
  logic  cfg_we = 1'b0;
  logic [mlbs_pkg::CFG_W-1:0] cfg_data = '0;
  mlbs_pkg::res_t  result;
  logic  result_valid;

  led_effect_t    led_effects[NUM_LEDS];
  logic [3:0]     model_led_count;
  mlbs_pkg::res_t tick_drives[$];
  mlbs_pkg::res_t expected_drives[$];
  logic [31:0]    now_ms;
  int             burst_left;
  int             err_count = 0;
  int             idle_cycles;

  multi_led_blink_sequencer #(
    .NUM_LEDS(NUM_LEDS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .result      (result),
    .result_valid(result_valid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Reset state of the predictor: dirty solid black entries, nothing in use
  task automatic reset_effects();
    foreach (led_effects[i]) begin
      led_effects[i] = '{8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'sd0, 32'd0, 1'b0, 1'b1};
    end
    model_led_count = '0;
  endtask

  task automatic load_effect(input int i, input mlbs_pkg::item_t it, input bit blink);
    led_effects[i].red   = it.red;
    led_effects[i].green = it.green;
    led_effects[i].blue  = it.blue;
    if (blink) begin
      led_effects[i].on_ms       = it.on_time;
      led_effects[i].off_ms      = it.off_time;
      led_effects[i].cycles_left = it.cycle_limit;
    end else begin
      led_effects[i].on_ms       = '0;
      led_effects[i].off_ms      = '0;
      led_effects[i].cycles_left = -16'sd1;
    end
    led_effects[i].phase_start = '0;
    led_effects[i].lit         = 1'b1;
    led_effects[i].dirty       = 1'b1;
  endtask

  task automatic add_drive(input int i, input logic lit);
    mlbs_pkg::res_t r;
    r.led_number  = i[mlbs_pkg::LED_NUM_W-1:0];
    r.lit         = lit;
    r.out_red     = led_effects[i].red;
    r.out_green   = led_effects[i].green;
    r.out_blue    = led_effects[i].blue;
    r.last_of_run = 1'b0;
    tick_drives.insert(tick_drives.size(), r);
  endtask

  // Advance the effect table by one transaction; fill tick_drives with the drives it causes
  task automatic predict_drives(input mlbs_pkg::item_t it);
    int n;
    logic [31:0] dur;
    tick_drives.delete();
    n = (model_led_count > NUM_LEDS) ? NUM_LEDS : int'(model_led_count);
    if (it.action == mlbs_pkg::ACT_SOLID || it.action == mlbs_pkg::ACT_BLINK) begin
      if (it.led_index[3]) begin
        for (int i = 0; i < n; i++) load_effect(i, it, it.action == mlbs_pkg::ACT_BLINK);
      end else if (int'(it.led_index[2:0]) < n) begin
        load_effect(int'(it.led_index[2:0]), it, it.action == mlbs_pkg::ACT_BLINK);
      end
    end else if (it.action == mlbs_pkg::ACT_TICK) begin
      for (int i = 0; i < n; i++) begin
        if (led_effects[i].on_ms == 0 && led_effects[i].off_ms == 0) begin
          // Solid entry: drive once when dirty
          if (led_effects[i].dirty) begin
            add_drive(i, 1'b1);
            led_effects[i].dirty = 1'b0;
          end
        end else if (led_effects[i].dirty) begin
          // Fresh blink: start the on phase now
          led_effects[i].phase_start = it.now_time;
          led_effects[i].lit         = 1'b1;
          led_effects[i].dirty       = 1'b0;
          add_drive(i, 1'b1);
        end else begin
          dur = led_effects[i].lit ? {16'd0, led_effects[i].on_ms}
                                   : {16'd0, led_effects[i].off_ms};
          if (it.now_time - led_effects[i].phase_start >= dur) begin
            if (led_effects[i].lit && led_effects[i].cycles_left > 0 &&
                led_effects[i].cycles_left == 1) begin
              // Last on phase of a bounded blink: settle to solid off
              led_effects[i].cycles_left = 16'sd0;
              led_effects[i].lit    = 1'b0;
              led_effects[i].on_ms  = '0;
              led_effects[i].off_ms = '0;
              add_drive(i, 1'b0);
            end else begin
              if (led_effects[i].lit && led_effects[i].cycles_left > 0)
                led_effects[i].cycles_left = led_effects[i].cycles_left - 16'sd1;
              led_effects[i].lit         = !led_effects[i].lit;
              led_effects[i].phase_start = it.now_time;
              add_drive(i, led_effects[i].lit);
            end
          end
        end
      end
      if (tick_drives.size() > 0) tick_drives[tick_drives.size() - 1].last_of_run = 1'b1;
    end
  endtask

  // Present one transaction and hold it until the block takes it; gaps come between bursts
  task automatic send_item(input mlbs_pkg::item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    burst_left--;
  endtask

  task automatic apply_item(input mlbs_pkg::item_t it);
    send_item(it);
    predict_drives(it);
    foreach (tick_drives[k]) expected_drives.insert(expected_drives.size(), tick_drives[k]);
  endtask

  // Hold off until every expected drive is in and the block has gone quiet
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    burst_left = 0;
    while (expected_drives.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_led_count(input logic [3:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    model_led_count = value;
  endtask

  function automatic mlbs_pkg::item_t mk_item(input logic [1:0] act, input logic [3:0] idx,
                                              input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b, input logic [15:0] on_t,
                                              input logic [15:0] off_t,
                                              input logic [15:0] cyc,
                                              input logic [31:0] now);
    mlbs_pkg::item_t it;
    it.action      = act;
    it.led_index   = idx;
    it.red         = r;
    it.green       = g;
    it.blue        = b;
    it.on_time     = on_t;
    it.off_time    = off_t;
    it.cycle_limit = cyc;
    it.now_time    = now;
    return it;
  endfunction

  // Tick at the given time, every other field zero
  function automatic mlbs_pkg::item_t mk_tick(input logic [31:0] now);
    return mk_item(mlbs_pkg::ACT_TICK, 4'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, now);
  endfunction

  function automatic stim_row_t cfg_row(input logic [3:0] value);
    stim_row_t row;
    row.is_cfg  = 1'b1;
    row.cfg_val = value;
    row.stim    = '0;
    row.chk     = 1'b0;
    row.exp     = '0;
    return row;
  endfunction

  function automatic stim_row_t item_row(input mlbs_pkg::item_t it, input bit chk = 1'b0,
                                         input mlbs_pkg::res_t exp = '0);
    stim_row_t row;
    row.is_cfg  = 1'b0;
    row.cfg_val = '0;
    row.stim    = it;
    row.chk     = chk;
    row.exp     = exp;
    return row;
  endfunction

  // Mostly short blink effects and ticks that step time forward, some full-range noise
  function automatic mlbs_pkg::item_t rand_item();
    mlbs_pkg::item_t it;
    int sel;
    sel = $urandom_range(0, 9);
    it.action = (sel < 2) ? mlbs_pkg::ACT_SOLID : (sel < 4) ? mlbs_pkg::ACT_BLINK :
                (sel == 4) ? ACT_NONE : mlbs_pkg::ACT_TICK;
    it.led_index = ($urandom_range(0, 3) == 0) ? 4'hF : 4'($urandom_range(0, 15));
    it.red   = 8'($urandom);
    it.green = 8'($urandom);
    it.blue  = 8'($urandom);
    sel = $urandom_range(0, 9);
    it.on_time = (sel < 7) ? 16'($urandom_range(0, 12)) : (sel == 7) ? 16'd0 : 16'($urandom);
    sel = $urandom_range(0, 9);
    it.off_time = (sel < 7) ? 16'($urandom_range(0, 12)) : (sel == 7) ? 16'd0 : 16'($urandom);
    it.cycle_limit = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 6) - 2);
    if (it.action == mlbs_pkg::ACT_TICK) begin
      now_ms = now_ms + (($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 15));
      it.now_time = now_ms;
    end else begin
      it.now_time = $urandom;
    end
    return it;
  endfunction

  // Compare every drive against the oldest expectation
  always @(posedge clk) begin : drive_check
    mlbs_pkg::res_t want;
    if (!rst && result_valid) begin
      if (expected_drives.size() == 0) begin
        report_mismatch($sformatf("unexpected drive for LED %0d", result.led_number));
      end else begin
        want = expected_drives.pop_front();
        check_field("led_number", 8'(result.led_number), 8'(want.led_number));
        check_field("lit", 8'(result.lit), 8'(want.lit));
        check_field("out_red", result.out_red, want.out_red);
        check_field("out_green", result.out_green, want.out_green);
        check_field("out_blue", result.out_blue, want.out_blue);
        check_field("last_of_run", 8'(result.last_of_run), 8'(want.last_of_run));
      end
    end
  end

  // Drop the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t rows[$];
    logic [3:0] phase_counts[$];
    burst_left  = 0;
    now_ms      = 32'd300;
    reset_effects();

    // Directed rows: first tick after reset, extremes, every action, wrap of time
    rows.insert(rows.size(), item_row(mk_tick(32'd0)));
    rows.insert(rows.size(), cfg_row(4'd1));
    rows.insert(rows.size(), item_row(mk_tick(32'd0), 1'b1,
                mlbs_pkg::res_t'{led_number: 3'd0, lit: 1'b1, out_red: 8'h00,
                                 out_green: 8'h00, out_blue: 8'h00, last_of_run: 1'b1}));
    rows.insert(rows.size(), item_row(mk_tick(32'd5)));
    rows.insert(rows.size(), item_row(mk_item(mlbs_pkg::ACT_SOLID, 4'd0, 8'hAA, 8'h55,
                8'hFF, 16'd9, 16'd9, 16'd3, 32'd0)));
    rows.insert(rows.size(), item_row(mk_tick(32'd6), 1'b1,
                mlbs_pkg::res_t'{led_number: 3'd0, lit: 1'b1, out_red: 8'hAA,
                                 out_green: 8'h55, out_blue: 8'hFF, last_of_run: 1'b1}));
    rows.insert(rows.size(), cfg_row(4'd8));
    rows.insert(rows.size(), item_row(mk_tick(32'd10)));
    rows.insert(rows.size(), item_row(mk_item(mlbs_pkg::ACT_SOLID, 4'hF, 8'hFF, 8'hFF,
                8'hFF, 16'd0, 16'd0, 16'd0, 32'd0)));
    rows.insert(rows.size(), item_row(mk_tick(32'd11)));
    rows.insert(rows.size(), item_row(mk_item(mlbs_pkg::ACT_BLINK, 4'd0, 8'h12, 8'h34,
                8'h56, 16'd3, 16'd2, 16'd2, 32'd0)));
    rows.insert(rows.size(), item_row(mk_item(mlbs_pkg::ACT_BLINK, 4'd7, 8'hFF, 8'h00,
                8'hFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 32'd0)));
    rows.insert(rows.size(), item_row(mk_item(mlbs_pkg::ACT_BLINK, 4'd1, 8'h01, 8'h80,
                8'h7F, 16'd0, 16'd5, 16'hFFFF, 32'd0)));
    rows.insert(rows.size(), item_row(mk_item(mlbs_pkg::ACT_BLINK, 4'd2, 8'h0F, 8'hF0,
                8'h3C, 16'd4, 16'd0, 16'd1, 32'd0)));
    rows.insert(rows.size(), item_row(mk_item(ACT_NONE, 4'hF, 8'hFF, 8'hFF, 8'hFF,
                16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF)));
    rows.insert(rows.size(), item_row(mk_tick(32'd100)));
    rows.insert(rows.size(), item_row(mk_tick(32'd103)));
    rows.insert(rows.size(), item_row(mk_tick(32'd105)));
    rows.insert(rows.size(), item_row(mk_tick(32'd108)));
    rows.insert(rows.size(), item_row(mk_tick(32'hFFFF_FFF0)));
    rows.insert(rows.size(), item_row(mk_tick(32'h0000_0010)));
    rows.insert(rows.size(), cfg_row(4'd3));
    rows.insert(rows.size(), item_row(mk_item(mlbs_pkg::ACT_SOLID, 4'd5, 8'h01, 8'h02,
                8'h03, 16'd0, 16'd0, 16'd0, 32'd0)));
    rows.insert(rows.size(), item_row(mk_item(mlbs_pkg::ACT_BLINK, 4'h8, 8'h40, 8'h20,
                8'h10, 16'd1, 16'd1, 16'h8000, 32'd0)));
    rows.insert(rows.size(), item_row(mk_tick(32'd20)));
    rows.insert(rows.size(), item_row(mk_tick(32'd21)));
    rows.insert(rows.size(), cfg_row(4'd15));
    rows.insert(rows.size(), item_row(mk_tick(32'd22)));

    // Hold reset, then release it on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[r]) begin
      if (rows[r].is_cfg) begin
        wait_idle();
        write_led_count(rows[r].cfg_val);
      end else if (rows[r].chk) begin
        send_item(rows[r].stim);
        predict_drives(rows[r].stim);
        expected_drives.insert(expected_drives.size(), rows[r].exp);
      end else begin
        apply_item(rows[r].stim);
      end
    end

    // Random phases over several LED counts, the extremes among them
    phase_counts = '{4'd8, 4'd15, 4'd0, 4'd4, 4'd1, 4'($urandom_range(0, 15))};
    foreach (phase_counts[p]) begin
      wait_idle();
      write_led_count(phase_counts[p]);
      for (int n = 0; n < RAND_ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 19) == 0) wait_idle();
        apply_item(rand_item());
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mlbs_pkg.sv
rtl/mlbs_ctrl.sv
rtl/mlbs_dp.sv
rtl/multi_led_blink_sequencer.sv
tb/tb_multi_led_blink_sequencer.sv
